/* src/rled_pkg.sv */
// ----------------------------------------------------------------------------
// rled_pkg: shared constants for the decimal run-length encoder
// Symbol and digit widths, the ASCII code of '0', the default count size
// and the depth of the run queue between the front and back parts.
// ----------------------------------------------------------------------------
package rled_pkg;

  localparam int unsigned SYM_W              = 8;
  localparam int unsigned DIGIT_W            = 4;
  localparam int unsigned COUNT_DIGITS_DEF   = 5;
  localparam int unsigned QUEUE_DEPTH_DEF    = 4;
  localparam logic [SYM_W-1:0] ASCII_ZERO    = 8'h30;

endpackage

/* src/run_length_encode_decimal.sv */
// ----------------------------------------------------------------------------
// run_length_encode_decimal: run-length encoder with decimal counts
// Byte stream in, encoded byte stream out, runs counted in BCD.
// ----------------------------------------------------------------------------
// Send one byte per transfer on the in_ channel, with in_tlast on the final
// byte of a stream. Each run comes out as its byte followed, when the run is
// longer than one, by the ASCII decimal digits of its length, most
// significant first, no leading zeros; out_tlast marks the final output byte
// of the stream. A run longer than COUNT_DIGITS nines is split. The block
// takes one byte every cycle as long as the run queue has room for two run
// records, and sends one output byte per cycle while out_tready is high,
// from a registered output stage; encoded output never outgrows input, so
// sustained rate is one byte per cycle. A finished run goes through the
// queue, run and output registers. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module run_length_encode_decimal #(
  parameter int unsigned COUNT_DIGITS = rled_pkg::COUNT_DIGITS_DEF,
  parameter int unsigned QUEUE_DEPTH  = rled_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [rled_pkg::SYM_W-1:0] in_tdata,   // [7:0] symbol
  input  logic                       in_tlast,   // end_of_input
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [rled_pkg::SYM_W-1:0] out_tdata,  // [7:0] out_symbol
  output logic                       out_tlast   // out_last
);
  import rled_pkg::*;

  localparam int unsigned REC_W = SYM_W + DIGIT_W * COUNT_DIGITS + 1;

  logic             take;
  logic             push_a_vld, push_b_vld;
  logic [REC_W-1:0] push_a_rec, push_b_rec;
  logic             pop, head_vld, room2;
  logic [REC_W-1:0] head_rec;

  // accept a byte only when the queue can absorb both runs it may close
  assign in_tready = room2;
  assign take      = in_tvalid && room2;

  // front: track the open run, hand closed runs to the queue
  rled_front #(
    .COUNT_DIGITS (COUNT_DIGITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .symbol       (in_tdata),
    .end_of_input (in_tlast),
    .push_a_vld   (push_a_vld),
    .push_a_rec   (push_a_rec),
    .push_b_vld   (push_b_vld),
    .push_b_rec   (push_b_rec)
  );

  // queue: decouple run tracking from byte emission
  rled_queue #(
    .REC_W (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_a_vld (push_a_vld),
    .push_a_rec (push_a_rec),
    .push_b_vld (push_b_vld),
    .push_b_rec (push_b_rec),
    .pop        (pop),
    .head_vld   (head_vld),
    .head_rec   (head_rec),
    .room2      (room2)
  );

  // back: spell out each run, one byte per transfer
  rled_back #(
    .COUNT_DIGITS (COUNT_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_vld   (head_vld),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* src/rled_front.sv */
// ----------------------------------------------------------------------------
// rled_front: run tracker
// Holds the open run (byte and BCD count) and hands finished runs to the
// run queue, up to two in one cycle (a run broken by a new byte, and the
// run closed by the end of the stream).
// Run record layout, low bits first: byte, BCD count, last flag.
// ----------------------------------------------------------------------------
module rled_front #(
  parameter int unsigned COUNT_DIGITS = rled_pkg::COUNT_DIGITS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                take,
  input  logic [rled_pkg::SYM_W-1:0]                          symbol,
  input  logic                                                end_of_input,
  output logic                                                push_a_vld,
  output logic [rled_pkg::SYM_W+rled_pkg::DIGIT_W*COUNT_DIGITS:0] push_a_rec,
  output logic                                                push_b_vld,
  output logic [rled_pkg::SYM_W+rled_pkg::DIGIT_W*COUNT_DIGITS:0] push_b_rec
);
  import rled_pkg::*;

  localparam int unsigned BCD_W = DIGIT_W * COUNT_DIGITS;
  localparam logic [BCD_W-1:0] ALL_NINES = {COUNT_DIGITS{4'h9}};
  localparam logic [BCD_W-1:0] BCD_ONE   = BCD_W'(1);

  logic [SYM_W-1:0] run_byte_r, run_byte_nxt;
  logic [BCD_W-1:0] count_r, count_nxt;
  logic             open_r, open_nxt;
  logic [BCD_W-1:0] count_inc;

  // ripple BCD increment, one digit a step
  always_comb begin
    logic             carry;
    logic [DIGIT_W-1:0] d;
    carry = 1'b1;
    count_inc = count_r;
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      d = count_r[i*DIGIT_W +: DIGIT_W];
      if (carry) begin
        if (d == 4'd9) begin
          count_inc[i*DIGIT_W +: DIGIT_W] = '0;
        end else begin
          count_inc[i*DIGIT_W +: DIGIT_W] = d + 4'd1;
          carry = 1'b0;
        end
      end
    end
  end

  always_comb begin
    run_byte_nxt = run_byte_r;
    count_nxt    = count_r;
    open_nxt     = open_r;
    push_a_vld   = 1'b0;
    push_b_vld   = 1'b0;
    push_a_rec   = {1'b0, count_r, run_byte_r};
    if (take) begin
      if (!open_r) begin
        run_byte_nxt = symbol;
        count_nxt    = BCD_ONE;
        open_nxt     = 1'b1;
      end else if (symbol == run_byte_r && count_r != ALL_NINES) begin
        count_nxt = count_inc;
      end else begin
        // close the held run, open a new one
        push_a_vld   = 1'b1;
        run_byte_nxt = symbol;
        count_nxt    = BCD_ONE;
      end
    end
    push_b_rec = {1'b1, count_nxt, run_byte_nxt};
    if (take && end_of_input) begin
      push_b_vld   = 1'b1;
      open_nxt     = 1'b0;
      run_byte_nxt = '0;
      count_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_byte_r <= '0;
      count_r    <= '0;
      open_r     <= 1'b0;
    end else begin
      run_byte_r <= run_byte_nxt;
      count_r    <= count_nxt;
      open_r     <= open_nxt;
    end
  end

endmodule

/* src/rled_queue.sv */
// ----------------------------------------------------------------------------
// rled_queue: run record queue
// Small flip-flop FIFO between front and back. Takes up to two records in
// one cycle, in order, and gives one record a cycle from its head, on pop.
// ----------------------------------------------------------------------------
module rled_queue #(
  parameter int unsigned REC_W = rled_pkg::SYM_W + 1,
  parameter int unsigned DEPTH = rled_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_a_vld,
  input  logic [REC_W-1:0] push_a_rec,
  input  logic             push_b_vld,
  input  logic [REC_W-1:0] push_b_rec,
  input  logic             pop,
  output logic             head_vld,
  output logic [REC_W-1:0] head_rec,
  output logic             room2
);
  import rled_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [REC_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;
  logic [1:0]       n_push;

  // advance a pointer by up to two slots, wrapping at the queue depth
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                input logic [1:0]       n);
    logic [PTR_W:0] s;
    s = {1'b0, p} + (PTR_W+1)'(n);
    if (s >= (PTR_W+1)'(DEPTH)) begin
      s = s - (PTR_W+1)'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  assign wr_ptr_p1 = ptr_add(wr_ptr_r, 2'd1);
  assign n_push    = 2'(push_a_vld) + 2'(push_b_vld);
  assign head_vld  = (cnt_r != '0);
  assign head_rec  = mem_r[rd_ptr_r];
  assign room2     = (cnt_r <= CNT_W'(DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = ptr_add(wr_ptr_r, n_push);
    rd_ptr_nxt = ptr_add(rd_ptr_r, 2'(pop));
    cnt_nxt    = cnt_r + CNT_W'(n_push) - CNT_W'(pop);
  end

  // payload: write a at the tail, b right after it (or at the tail alone)
  always_ff @(posedge clk) begin
    if (push_a_vld) begin
      mem_r[wr_ptr_r] <= push_a_rec;
      if (push_b_vld) begin
        mem_r[wr_ptr_p1] <= push_b_rec;
      end
    end else if (push_b_vld) begin
      mem_r[wr_ptr_r] <= push_b_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* src/rled_back.sv */
// ----------------------------------------------------------------------------
// rled_back: run emitter
// Takes run records from the queue and sends the run byte, then the
// decimal digits of the count (none for a count of one), one byte a cycle
// while out_tready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module rled_back #(
  parameter int unsigned COUNT_DIGITS = rled_pkg::COUNT_DIGITS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                head_vld,
  input  logic [rled_pkg::SYM_W+rled_pkg::DIGIT_W*COUNT_DIGITS:0] head_rec,
  output logic                                                pop,
  output logic                                                out_tvalid,
  input  logic                                                out_tready,
  output logic [rled_pkg::SYM_W-1:0]                          out_tdata,
  output logic                                                out_tlast
);
  import rled_pkg::*;

  localparam int unsigned BCD_W = DIGIT_W * COUNT_DIGITS;
  localparam int unsigned CNT_W = $clog2(COUNT_DIGITS + 1);
  localparam int unsigned LZ_W  = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;

  logic [SYM_W-1:0] head_byte;
  logic [BCD_W-1:0] head_bcd;
  logic             head_last;
  logic [LZ_W-1:0]  head_lz;
  logic [CNT_W-1:0] head_ndig;
  logic [BCD_W-1:0] head_aligned;

  logic             cur_vld_r, cur_vld_nxt;
  logic [SYM_W-1:0] cur_byte_r, cur_byte_nxt;
  logic [BCD_W-1:0] cur_sh_r, cur_sh_nxt;
  logic             cur_last_r, cur_last_nxt;
  logic             in_byte_r, in_byte_nxt;
  logic [CNT_W-1:0] dig_left_r, dig_left_nxt;

  logic             out_vld_r, out_vld_nxt;
  logic [SYM_W-1:0] out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;

  logic [SYM_W-1:0] em_data;
  logic             em_done;
  logic             adv;
  logic             need_load;

  assign head_byte = head_rec[SYM_W-1:0];
  assign head_bcd  = head_rec[SYM_W +: BCD_W];
  assign head_last = head_rec[SYM_W+BCD_W];

  // leading zero digits and digit count of the head record
  always_comb begin
    head_lz   = LZ_W'(0);
    head_ndig = CNT_W'(0);
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      if (head_bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
        head_lz   = LZ_W'(COUNT_DIGITS - 1 - i);
        head_ndig = CNT_W'(i + 1);
      end
    end
    if (head_bcd <= BCD_W'(1)) begin
      head_ndig = CNT_W'(0);
    end
  end

  assign head_aligned = head_bcd << {head_lz, 2'b00};

  assign em_data = in_byte_r ? cur_byte_r
                             : ASCII_ZERO + SYM_W'(cur_sh_r[BCD_W-1 -: DIGIT_W]);
  assign em_done = in_byte_r ? (dig_left_r == CNT_W'(0)) : (dig_left_r == CNT_W'(1));
  assign adv       = cur_vld_r && (!out_vld_r || out_tready);
  assign need_load = !cur_vld_r || (adv && em_done);
  assign pop       = need_load && head_vld;

  always_comb begin
    cur_vld_nxt  = cur_vld_r;
    cur_byte_nxt = cur_byte_r;
    cur_sh_nxt   = cur_sh_r;
    cur_last_nxt = cur_last_r;
    in_byte_nxt  = in_byte_r;
    dig_left_nxt = dig_left_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    if (adv) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = em_data;
      out_last_nxt = cur_last_r && em_done;
      if (in_byte_r) begin
        in_byte_nxt = 1'b0;
      end else begin
        cur_sh_nxt   = cur_sh_r << DIGIT_W;
        dig_left_nxt = dig_left_r - CNT_W'(1);
      end
    end
    if (need_load) begin
      cur_vld_nxt = head_vld;
      if (head_vld) begin
        cur_byte_nxt = head_byte;
        cur_sh_nxt   = head_aligned;
        cur_last_nxt = head_last;
        in_byte_nxt  = 1'b1;
        dig_left_nxt = head_ndig;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    cur_byte_r <= cur_byte_nxt;
    cur_sh_r   <= cur_sh_nxt;
    cur_last_r <= cur_last_nxt;
    in_byte_r  <= in_byte_nxt;
    dig_left_r <= dig_left_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

/* tb/rle_decimal_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_decimal_checker: scoreboard for the decimal run-length encoder
// Follows every input transfer with its own run tracker, queues the encoded
// bytes that each byte causes, and compares every output transfer, data and
// last flag, with the oldest queued byte.
// ----------------------------------------------------------------------------
module rle_decimal_checker #(
  parameter int unsigned COUNT_DIGITS = rled_pkg::COUNT_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [rled_pkg::SYM_W-1:0] in_tdata,
  input  logic                       in_tlast,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [rled_pkg::SYM_W-1:0] out_tdata,
  input  logic                       out_tlast,
  output int unsigned                mismatches,
  output int unsigned                pending
);

  localparam int unsigned BCD_W = rled_pkg::DIGIT_W * COUNT_DIGITS;

  typedef struct packed {
    logic [rled_pkg::SYM_W-1:0] data;
    logic                       last;
  } enc_byte_t;

  enc_byte_t                  due_bytes[$];
  logic [rled_pkg::SYM_W-1:0] run_sym;
  logic [BCD_W-1:0]           run_bcd;
  logic                       run_held;
  int unsigned                out_index;

  function automatic logic [BCD_W-1:0] bcd_full();
    logic [BCD_W-1:0] r;
    r = '0;
    for (int i = 0; i < COUNT_DIGITS; i++) r[4*i +: 4] = 4'd9;
    return r;
  endfunction

  // Ripple the carry up while digits wrap from nine.
  function automatic logic [BCD_W-1:0] bcd_plus_one(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    bit               carry;
    r     = v;
    carry = 1'b1;
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      if (carry) begin
        if (r[4*i +: 4] == 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = r[4*i +: 4] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Queue the held run: its byte, then the count digits without leading zeros.
  task automatic emit_run(input bit mark_last);
    enc_byte_t   e;
    int          top;
    bit          has_count;
    has_count = (run_bcd > 1);
    e.data    = run_sym;
    e.last    = mark_last && !has_count;
    due_bytes = {due_bytes, e};
    if (has_count) begin
      top = 0;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
        if (run_bcd[4*i +: 4] != 4'd0) top = i;
      end
      for (int i = top; i >= 0; i--) begin
        e.data    = rled_pkg::ASCII_ZERO + run_bcd[4*i +: 4];
        e.last    = mark_last && (i == 0);
        due_bytes = {due_bytes, e};
      end
    end
  endtask

  task automatic take_symbol(input logic [rled_pkg::SYM_W-1:0] s, input logic eos);
    if (!run_held) begin
      run_sym  = s;
      run_bcd  = BCD_W'(1);
      run_held = 1'b1;
    end else if (s == run_sym && run_bcd != bcd_full()) begin
      run_bcd = bcd_plus_one(run_bcd);
    end else begin
      emit_run(1'b0);
      run_sym = s;
      run_bcd = BCD_W'(1);
    end
    if (eos) begin
      emit_run(1'b1);
      run_held = 1'b0;
      run_sym  = '0;
      run_bcd  = '0;
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] output byte %0d: %s", $realtime, out_index, what);
  endtask

  always @(posedge clk) begin
    enc_byte_t want;
    if (!rst_n) begin
      run_sym  = '0;
      run_bcd  = '0;
      run_held = 1'b0;
      due_bytes.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_bytes.size() == 0) begin
          note_mismatch($sformatf("unexpected, got data %02h last %0b", out_tdata, out_tlast));
        end else begin
          want = due_bytes.pop_front();
          if (out_tdata !== want.data || out_tlast !== want.last) begin
            note_mismatch($sformatf("expected data %02h last %0b, got data %02h last %0b",
                                    want.data, want.last, out_tdata, out_tlast));
          end
        end
        out_index++;
      end
      if (in_tvalid && in_tready) take_symbol(in_tdata, in_tlast);
    end
    pending = due_bytes.size();
  end

endmodule

/* tb/run_length_encode_decimal_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// run_length_encode_decimal_test: stream test of the decimal run-length encoder
// Drives directed and random byte streams into the encoder under varying
// sender and receiver idling, with one long receiver hold-off. A checker
// beside the block predicts and compares every output byte; this module
// makes stimulus and decides.
// ----------------------------------------------------------------------------
module run_length_encode_decimal_test;

  import rled_pkg::*;

  localparam int unsigned COUNT_DIGITS    = COUNT_DIGITS_DEF;
  localparam int unsigned PHASE_ITEMS     = 100;    // random bytes per idling phase
  localparam int unsigned HOLD_OFF_CYCLES = 400;    // receiver stall to back up the block
  localparam int unsigned STALL_LIMIT     = 5000;   // cycles without any transfer
  localparam int unsigned DRAIN_CYCLES    = 16;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [SYM_W-1:0] in_tdata   = '0;   // [7:0] symbol
  logic             in_tlast   = 1'b0; // end_of_input
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [SYM_W-1:0] out_tdata;         // [7:0] out_symbol
  logic             out_tlast;         // out_last

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req      = 0;      // bump to ask the receiver for a hold-off
  int unsigned items_sent    = 0;
  int unsigned mismatches;
  int unsigned pending;

  run_length_encode_decimal #(
    .COUNT_DIGITS (COUNT_DIGITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  rle_decimal_checker #(
    .COUNT_DIGITS (COUNT_DIGITS)
  ) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver: random back-pressure, or one long hold-off when requested.
  initial begin : receiver
    int unsigned seen_req;
    seen_req = 0;
    forever begin
      @(posedge clk);
      if (hold_req != seen_req) begin
        seen_req = hold_req;
        out_tready <= 1'b0;
        // Hold ready low for the whole stretch; the sender keeps offering.
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run once the channels have been quiet too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Offer one byte, after an optional random gap, and wait for its transfer.
  // Valid stays high on return so back-to-back bytes go out without a gap.
  task automatic send_byte(input logic [SYM_W-1:0] s, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Send len copies of one byte; mark the final copy last when asked.
  task automatic send_run(input logic [SYM_W-1:0] s, input int unsigned len,
                          input bit close);
    for (int unsigned i = 0; i < len; i++) send_byte(s, close && (i == len - 1));
  endtask

  // One stream ending in a last byte: mostly runs with random bytes and
  // lengths, sometimes plain noise with few repeats.
  task automatic random_stream();
    int unsigned      n_runs;
    int unsigned      len;
    int unsigned      pick;
    logic [SYM_W-1:0] sym;
    if ($urandom_range(99) < 20) begin
      len = $urandom_range(1, 12);
      for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == len - 1);
    end else begin
      n_runs = $urandom_range(1, 6);
      for (int unsigned r = 0; r < n_runs; r++) begin
        // Draw from a narrow alphabet often, so neighboring runs may merge.
        pick = $urandom_range(99);
        sym  = (pick < 60) ? 8'($urandom_range(255)) : 8'h41 + 8'($urandom_range(3));
        pick = $urandom_range(99);
        if (pick < 45)      len = 1;
        else if (pick < 85) len = $urandom_range(2, 9);
        else if (pick < 98) len = $urandom_range(10, 30);
        else                len = $urandom_range(95, 120);
        send_run(sym, len, r == n_runs - 1);
      end
    end
  endtask

  task automatic random_phase(input int unsigned items);
    int unsigned stop_at;
    stop_at = items_sent + items;
    while (items_sent < stop_at) random_stream();
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 19;
    recv_idle_pct = 54;

    // Directed streams.
    send_run(8'h00, 1, 1'b1);   // lone byte that is also the end of stream
    send_run(8'hFF, 2, 1'b1);   // shortest counted run
    send_run(8'h41, 9, 1'b0);   // single-digit count closed by a new byte
    send_run(8'h42, 1, 1'b1);
    send_run(8'h30, 10, 1'b1);  // run byte equal to ASCII zero, two-digit count
    send_run(8'h55, 1, 1'b0);   // alternating bit patterns, no repeats
    send_run(8'hAA, 1, 1'b0);
    send_run(8'h55, 1, 1'b1);

    random_phase(PHASE_ITEMS);

    // Swap the idling sides.
    send_idle_pct = 54;
    recv_idle_pct = 19;
    random_phase(PHASE_ITEMS);

    // No idling; start with a long receiver hold-off so the block fills up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req++;
    random_phase(PHASE_ITEMS);

    in_tvalid <= 1'b0;
    // Let the checker take in the final transfer before watching the backlog.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
